>>> hdl/atapio_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO sector transfer package
// Shared types, codes and constants for the PIO LBA28 transfer sequencer.
// ----------------------------------------------------------------------------
package atapio_pkg;

	localparam int WORDS_PER_SECTOR = 256;
	localparam int DRIVE_SLOTS      = 4;
	localparam int WORD_IDX_W       = $clog2(WORDS_PER_SECTOR);

	// input actions
	localparam logic [1:0] ACT_START_RD = 2'd0;
	localparam logic [1:0] ACT_START_WR = 2'd1;
	localparam logic [1:0] ACT_STATUS   = 2'd2;
	localparam logic [1:0] ACT_DATA     = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_REG_WR  = 2'd0;
	localparam logic [1:0] KIND_HOST_WD = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;

	// outcomes
	localparam logic [1:0] OC_OK        = 2'd0;
	localparam logic [1:0] OC_BAD_DRIVE = 2'd1;
	localparam logic [1:0] OC_TIMEOUT   = 2'd2;
	localparam logic [1:0] OC_DEV_ERR   = 2'd3;

	// task-file offsets
	localparam logic [2:0] TF_DATA    = 3'd0;
	localparam logic [2:0] TF_COUNT   = 3'd2;
	localparam logic [2:0] TF_LBA_LO  = 3'd3;
	localparam logic [2:0] TF_LBA_MID = 3'd4;
	localparam logic [2:0] TF_LBA_HI  = 3'd5;
	localparam logic [2:0] TF_DRIVE   = 3'd6;
	localparam logic [2:0] TF_COMMAND = 3'd7;

	// commands and status bits
	localparam logic [7:0] CMD_READ     = 8'h20;
	localparam logic [7:0] CMD_WRITE    = 8'h30;
	localparam logic [7:0] CMD_FLUSH    = 8'hE7;
	localparam logic [7:0] DRV_SEL_BASE = 8'hE0;
	localparam int         ST_BSY_BIT   = 7;
	localparam int         ST_DRQ_BIT   = 3;
	localparam int         ST_ERR_BIT   = 0;

	// configuration registers
	localparam logic       REG_PRESENT_MASK = 1'b0;
	localparam logic       REG_POLL_LIMIT   = 1'b1;
	localparam logic [15:0] POLL_LIMIT_RST  = 16'd1250;

	// job codes from front to back
	localparam logic [2:0] JOB_DONE       = 3'd0;
	localparam logic [2:0] JOB_TASKFILE   = 3'd1;
	localparam logic [2:0] JOB_WORD       = 3'd2;
	localparam logic [2:0] JOB_WORD_FLUSH = 3'd3;
	localparam logic [2:0] JOB_WORD_DONE  = 3'd4;

	localparam int JQ_DEPTH = 4;
	localparam int JQ_AW    = $clog2(JQ_DEPTH);

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  drive_index;
		logic [27:0] lba;
		logic [7:0]  num_sectors;
		logic [7:0]  status_byte;
		logic [7:0]  error_byte;
		logic [15:0] data_word;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        channel;
		logic [2:0]  reg_offset;
		logic [15:0] value;
		logic [1:0]  outcome;
		logic [7:0]  device_error;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]  code;
		logic        channel;
		logic        drv_slave;
		logic        is_write;
		logic [27:0] lba;
		logic [7:0]  count;
		logic [15:0] data;
		logic [1:0]  outcome;
		logic [7:0]  dev_err;
	} job_t;

	typedef struct packed {
		logic        we;
		logic        index;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

`default_nettype wire

>>> hdl/atapio_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO front end
// Holds the transfer state and config; turns each item into at most one job.
// ----------------------------------------------------------------------------
module atapio_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 accept,
	input  atapio_pkg::item_t   item,
	input  atapio_pkg::cfg_wr_t cfg,
	output logic                job_push,
	output atapio_pkg::job_t    job
);
	import atapio_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_READY = 3'd1;
	localparam logic [2:0] PH_NBUSY = 3'd2;
	localparam logic [2:0] PH_DRQ   = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_FLUSH = 3'd5;

	localparam logic [2:0]            SLOTS    = 3'(DRIVE_SLOTS);
	localparam logic [WORD_IDX_W-1:0] WORD_MAX = WORD_IDX_W'(WORDS_PER_SECTOR - 1);

	logic [3:0]            present_mask_q;
	logic [15:0]           poll_limit_q;
	logic [2:0]            phase_q, phase_d;
	logic [15:0]           poll_count_q, poll_count_d;
	logic [WORD_IDX_W-1:0] word_index_q, word_index_d;
	logic [7:0]            sectors_left_q, sectors_left_d;
	logic [1:0]            active_drive_q, active_drive_d;
	logic                  is_write_q, is_write_d;
	logic [27:0]           start_lba_q, start_lba_d;
	logic [7:0]            start_count_q, start_count_d;

	logic [16:0] poll_next;
	logic        timed_out;
	logic        bsy, drq, err, bad_drive;
	logic [7:0]  sectors_dec;

	assign poll_next   = {1'b0, poll_count_q} + 17'd1;
	assign timed_out   = poll_next >= {1'b0, poll_limit_q};
	assign bsy         = item.status_byte[ST_BSY_BIT];
	assign drq         = item.status_byte[ST_DRQ_BIT];
	assign err         = item.status_byte[ST_ERR_BIT];
	assign bad_drive   = (item.drive_index >= SLOTS) || !present_mask_q[item.drive_index[1:0]];
	assign sectors_dec = sectors_left_q - 8'd1;

	always_comb begin
		phase_d        = phase_q;
		poll_count_d   = poll_count_q;
		word_index_d   = word_index_q;
		sectors_left_d = sectors_left_q;
		active_drive_d = active_drive_q;
		is_write_d     = is_write_q;
		start_lba_d    = start_lba_q;
		start_count_d  = start_count_q;
		job_push       = 1'b0;
		job            = '0;
		job.channel    = active_drive_q[1];
		job.drv_slave  = active_drive_q[0];
		job.is_write   = is_write_q;
		job.lba        = start_lba_q;
		job.count      = start_count_q;
		job.data       = item.data_word;
		job.code       = JOB_DONE;

		if (phase_q == PH_IDLE) begin
			if (item.action == ACT_START_RD || item.action == ACT_START_WR) begin
				if (bad_drive) begin
					job_push    = 1'b1;
					job.outcome = OC_BAD_DRIVE;
				end else if (item.num_sectors == 8'd0) begin
					job_push    = 1'b1;
					job.outcome = OC_OK;
				end else begin
					active_drive_d = item.drive_index[1:0];
					is_write_d     = item.action[0];
					start_lba_d    = item.lba;
					start_count_d  = item.num_sectors;
					sectors_left_d = item.num_sectors;
					word_index_d   = '0;
					phase_d        = PH_READY;
					poll_count_d   = '0;
				end
			end
		end else if (item.action == ACT_STATUS) begin
			case (phase_q)
				PH_READY, PH_NBUSY, PH_FLUSH: begin
					if (!bsy) begin
						if (phase_q == PH_READY) begin
							job_push     = 1'b1;
							job.code     = JOB_TASKFILE;
							phase_d      = is_write_q ? PH_DRQ : PH_NBUSY;
							poll_count_d = '0;
						end else if (phase_q == PH_NBUSY) begin
							phase_d      = PH_DRQ;
							poll_count_d = '0;
						end else begin
							sectors_left_d = sectors_dec;
							if (sectors_dec == 8'd0) begin
								job_push    = 1'b1;
								job.outcome = OC_OK;
								phase_d     = PH_IDLE;
							end else begin
								phase_d      = PH_DRQ;
								poll_count_d = '0;
							end
						end
					end else if (timed_out) begin
						job_push    = 1'b1;
						job.outcome = OC_TIMEOUT;
						phase_d     = PH_IDLE;
					end else begin
						poll_count_d = poll_next[15:0];
					end
				end
				PH_DRQ: begin
					if (drq) begin
						phase_d      = PH_DATA;
						word_index_d = '0;
					end else if (err) begin
						job_push    = 1'b1;
						job.outcome = OC_DEV_ERR;
						job.dev_err = item.error_byte;
						phase_d     = PH_IDLE;
					end else if (timed_out) begin
						job_push    = 1'b1;
						job.outcome = OC_TIMEOUT;
						phase_d     = PH_IDLE;
					end else begin
						poll_count_d = poll_next[15:0];
					end
				end
				default: begin
				end
			endcase
		end else if (item.action == ACT_DATA && phase_q == PH_DATA) begin
			job_push     = 1'b1;
			job.code     = JOB_WORD;
			word_index_d = word_index_q + 1'b1;
			if (word_index_q == WORD_MAX) begin
				word_index_d = '0;
				if (is_write_q) begin
					job.code     = JOB_WORD_FLUSH;
					phase_d      = PH_FLUSH;
					poll_count_d = '0;
				end else begin
					sectors_left_d = sectors_dec;
					if (sectors_dec == 8'd0) begin
						job.code = JOB_WORD_DONE;
						phase_d  = PH_IDLE;
					end else begin
						phase_d      = PH_NBUSY;
						poll_count_d = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_mask_q <= '0;
			poll_limit_q   <= POLL_LIMIT_RST;
			phase_q        <= PH_IDLE;
			poll_count_q   <= '0;
			word_index_q   <= '0;
			sectors_left_q <= '0;
			active_drive_q <= '0;
			is_write_q     <= 1'b0;
			start_lba_q    <= '0;
			start_count_q  <= '0;
		end else begin
			if (cfg.we) begin
				if (cfg.index == REG_PRESENT_MASK) begin
					present_mask_q <= cfg.data[3:0];
				end else begin
					poll_limit_q <= cfg.data;
				end
			end
			if (accept) begin
				phase_q        <= phase_d;
				poll_count_q   <= poll_count_d;
				word_index_q   <= word_index_d;
				sectors_left_q <= sectors_left_d;
				active_drive_q <= active_drive_d;
				is_write_q     <= is_write_d;
				start_lba_q    <= start_lba_d;
				start_count_q  <= start_count_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/atapio_jobq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO job queue
// Small queue of jobs between the front end and the result generator.
// ----------------------------------------------------------------------------
module atapio_jobq (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr_en,
	input  atapio_pkg::job_t  wr_job,
	input  wire               rd_en,
	output atapio_pkg::job_t  rd_job,
	output logic              not_empty,
	output logic              is_full
);
	import atapio_pkg::*;

	localparam logic [JQ_AW:0] DEPTH_V = (JQ_AW + 1)'(JQ_DEPTH);

	job_t             entry_q [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [JQ_AW:0]   count_q;

	assign rd_job    = entry_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign is_full   = count_q == DEPTH_V;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/atapio_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO result generator
// Expands each job into its result transfers, one per cycle while the
// output register is free or being popped, and holds them in that register.
// ----------------------------------------------------------------------------
module atapio_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                jq_not_empty,
	input  atapio_pkg::job_t   jq_job,
	output logic               jq_pop,
	output atapio_pkg::result_t res,
	output logic               res_valid,
	input  wire                res_take
);
	import atapio_pkg::*;

	job_t       job_q;
	logic       job_valid_q;
	logic [2:0] step_q;
	result_t    res_q;
	logic       res_valid_q;

	logic       out_free, adv, final_step;
	logic [2:0] last_step;
	result_t    gen;

	always_comb begin
		case (job_q.code)
			JOB_TASKFILE:                 last_step = 3'd5;
			JOB_WORD_FLUSH, JOB_WORD_DONE: last_step = 3'd1;
			default:                      last_step = 3'd0;
		endcase
	end

	assign out_free   = !res_valid_q || res_take;
	assign adv        = job_valid_q && out_free;
	assign final_step = step_q == last_step;
	assign jq_pop     = jq_not_empty && (!job_valid_q || (adv && final_step));

	always_comb begin
		gen         = '0;
		gen.channel = job_q.channel;
		gen.last    = final_step;
		case (job_q.code)
			JOB_TASKFILE: begin
				gen.kind = KIND_REG_WR;
				case (step_q)
					3'd0: begin
						gen.reg_offset = TF_DRIVE;
						gen.value = {8'h00, DRV_SEL_BASE | {3'b000, job_q.drv_slave,
							job_q.lba[27:24]}};
					end
					3'd1: begin
						gen.reg_offset = TF_COUNT;
						gen.value      = {8'h00, job_q.count};
					end
					3'd2: begin
						gen.reg_offset = TF_LBA_LO;
						gen.value      = {8'h00, job_q.lba[7:0]};
					end
					3'd3: begin
						gen.reg_offset = TF_LBA_MID;
						gen.value      = {8'h00, job_q.lba[15:8]};
					end
					3'd4: begin
						gen.reg_offset = TF_LBA_HI;
						gen.value      = {8'h00, job_q.lba[23:16]};
					end
					default: begin
						gen.reg_offset = TF_COMMAND;
						gen.value      = {8'h00, job_q.is_write ? CMD_WRITE : CMD_READ};
					end
				endcase
			end
			JOB_WORD, JOB_WORD_FLUSH, JOB_WORD_DONE: begin
				if (step_q == 3'd0) begin
					gen.kind       = job_q.is_write ? KIND_REG_WR : KIND_HOST_WD;
					gen.reg_offset = TF_DATA;
					gen.value      = job_q.data;
				end else if (job_q.code == JOB_WORD_FLUSH) begin
					gen.kind       = KIND_REG_WR;
					gen.reg_offset = TF_COMMAND;
					gen.value      = {8'h00, CMD_FLUSH};
				end else begin
					gen.kind    = KIND_DONE;
					gen.channel = 1'b0;
					gen.outcome = OC_OK;
				end
			end
			default: begin
				gen.kind         = KIND_DONE;
				gen.channel      = 1'b0;
				gen.outcome      = job_q.outcome;
				gen.device_error = job_q.dev_err;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (jq_pop) begin
			job_q <= jq_job;
		end
		if (adv) begin
			res_q <= gen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (jq_pop) begin
				job_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (adv) begin
				if (final_step) begin
					job_valid_q <= 1'b0;
				end
				step_q <= step_q + 1'b1;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (res_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

>>> hdl/ata_pio_sector_transfer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sector transfer sequencer
// Host-side read/write sequencer: task-file setup, status polling, sector data.
// ----------------------------------------------------------------------------
// Usage: push one item per cycle while full is low; status samples and data
// words are taken back to back. Every item is classified in the cycle it is
// accepted and at most one job enters a four-entry job queue. The result
// generator drains that queue at one result transfer per cycle while pop
// keeps the output register free, so a data word yields one result, a
// sector-end word with flush or done two, and the task-file setup (drive
// select, count, three LBA bytes, command) six. The queue lets the input keep
// running while those results drain; full rises only when four jobs are
// waiting. Each job is picked up into the job register and its results are
// held in the output register until popped; with the queue and generator
// empty, the first result of an item goes through the queue entry, the job
// register and the output register. Configuration registers (present_mask at
// index 0, poll_limit at index 1) are always writable; cfg_ready is tied high.
// ----------------------------------------------------------------------------
module ata_pio_sector_transfer (
	input  wire                  clk,
	input  wire                  arst_n,
	// input queue side
	input  wire                  push,
	output logic                 full,
	input  atapio_pkg::item_t    item,
	// result queue side
	output logic                 empty,
	input  wire                  pop,
	output atapio_pkg::result_t  result,
	// configuration write channel
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire                  cfg_index,
	input  wire [15:0]           cfg_data
);
	import atapio_pkg::*;

	logic    accept;
	logic    job_push;
	job_t    fe_job;
	job_t    jq_job;
	logic    jq_pop, jq_not_empty, jq_full;
	logic    res_valid;
	cfg_wr_t cfg;

	// an item transfer happens when the job queue has a free slot
	assign full      = jq_full;
	assign accept    = push && !jq_full;
	assign cfg_ready = 1'b1;

	always_comb begin
		cfg.we    = cfg_valid;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	// front: phase, poll counting, sector and word bookkeeping
	atapio_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg),
		.job_push (job_push),
		.job      (fe_job)
	);

	// jobs only enter on an accepted item
	atapio_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept && job_push),
		.wr_job    (fe_job),
		.rd_en     (jq_pop),
		.rd_job    (jq_job),
		.not_empty (jq_not_empty),
		.is_full   (jq_full)
	);

	// back: one result transfer per cycle while the output register is free
	atapio_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.jq_not_empty (jq_not_empty),
		.jq_job       (jq_job),
		.jq_pop       (jq_pop),
		.res          (result),
		.res_valid    (res_valid),
		.res_take     (pop)
	);

	assign empty = !res_valid;

endmodule

`default_nettype wire

>>> hdl/atapio_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO port checker
// Port-level checks on result transfers, bound to the top level.
// ----------------------------------------------------------------------------
module atapio_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 empty,
	input wire                 pop,
	input atapio_pkg::result_t result
);
	import atapio_pkg::*;

	// a waiting result holds until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	// a done ends the item's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_DONE) |-> result.last)
		else $error("done without last");

	// only done results carry an outcome or error byte
	a_outcome_done_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != KIND_DONE) |->
		(result.outcome == OC_OK && result.device_error == 8'd0))
		else $error("outcome on non-done result");

	// error byte only on device error
	a_err_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.outcome != OC_DEV_ERR) |-> result.device_error == 8'd0)
		else $error("error byte without device error");

endmodule

bind ata_pio_sector_transfer atapio_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire

>>> dv/ata_pio_sector_transfer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO sector transfer testbench
// Drives start, status and data items into the sequencer and checks every
// result against a cycle-free predictor of the transfer. A short table of
// corner cases runs first, ending in an open written sector that is then
// finished. Randomized traffic follows, shaped by the predicted transfer
// phase, under three sender/receiver stall profiles.
// ----------------------------------------------------------------------------
module ata_pio_sector_transfer_tb;
	import atapio_pkg::*;

	localparam int PHASE_ITEMS   = 15;   // counted items per random phase
	localparam int SETTLE_CYCLES = 16;   // job queue depth plus output register, with margin
	localparam int TAIL_CYCLES   = 20;
	localparam int QUIET_LIMIT   = 2000; // cycles without any transfer before giving up

	// transfer phases tracked by the predictor
	typedef enum logic [2:0] {
		XF_IDLE, XF_READY, XF_NBUSY, XF_DRQ, XF_DATA, XF_FLUSH
	} xfer_phase_t;

	// one row of the directed table: either a register write or an item,
	// optionally with a done result typed in by hand
	typedef struct packed {
		logic        is_cfg;
		logic        cfg_idx;
		logic [15:0] cfg_val;
		logic        typed;
		item_t       it;
		result_t     want;
	} stim_row_t;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    push      = 1'b0;
	logic    full;
	item_t   item      = '0;
	logic    empty;
	logic    pop       = 1'b0;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	// stall profile, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int mismatches   = 0;
	int quiet_cycles = 0;

	// predictor copy of configuration and transfer state
	logic [3:0]  cfg_present;
	logic [15:0] cfg_poll_limit;
	xfer_phase_t xf_phase;
	logic [15:0] xf_polls;
	int          xf_word;
	logic [7:0]  xf_sectors;
	logic [1:0]  xf_drive;
	logic        xf_write;
	logic [27:0] xf_lba;
	logic [7:0]  xf_count;

	result_t   step_results[$];     // results of the item just predicted
	logic      step_used;           // item changed something in the block
	result_t   xfer_results_due[$]; // in order, oldest first
	stim_row_t rows[$];

	ata_pio_sector_transfer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void emit(logic [1:0] k, logic ch, logic [2:0] ofs,
			logic [15:0] val, logic [1:0] oc, logic [7:0] err);
		result_t r;
		r.kind         = k;
		r.channel      = ch;
		r.reg_offset   = ofs;
		r.value        = val;
		r.outcome      = oc;
		r.device_error = err;
		r.last         = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void finish_xfer(logic [1:0] oc, logic [7:0] err);
		emit(KIND_DONE, 1'b0, TF_DATA, 16'h0000, oc, err);
		xf_phase = XF_IDLE;
	endfunction

	function automatic void enter_wait(xfer_phase_t ph);
		xf_phase = ph;
		xf_polls = '0;
	endfunction

	// one more failed poll; true once the wait has used up its allowance
	function automatic logic poll_exhausted();
		logic [16:0] c;
		c = {1'b0, xf_polls} + 17'd1;
		if (c >= {1'b0, cfg_poll_limit})
			return 1'b1;
		xf_polls = c[15:0];
		return 1'b0;
	endfunction

	function automatic void predict_transfer(item_t it);
		logic ch;
		step_results.delete();
		step_used = 1'b0;
		ch = xf_drive[1];
		if (xf_phase == XF_IDLE) begin
			if (it.action == ACT_START_RD || it.action == ACT_START_WR) begin
				step_used = 1'b1;
				if (it.drive_index >= DRIVE_SLOTS || !cfg_present[it.drive_index[1:0]])
					finish_xfer(OC_BAD_DRIVE, 8'h00);
				else if (it.num_sectors == 8'd0)
					finish_xfer(OC_OK, 8'h00);
				else begin
					xf_drive   = it.drive_index[1:0];
					xf_write   = (it.action == ACT_START_WR);
					xf_lba     = it.lba;
					xf_count   = it.num_sectors;
					xf_sectors = it.num_sectors;
					xf_word    = 0;
					enter_wait(XF_READY);
				end
			end
		end else if (it.action == ACT_STATUS) begin
			if (xf_phase != XF_DATA)
				step_used = 1'b1;
			case (xf_phase)
				XF_READY: begin
					if (!it.status_byte[ST_BSY_BIT]) begin
						// drive select, count, LBA low/mid/high, then the command
						emit(KIND_REG_WR, ch, TF_DRIVE,
							{8'h00, DRV_SEL_BASE | {3'b000, xf_drive[0], xf_lba[27:24]}},
							OC_OK, 8'h00);
						emit(KIND_REG_WR, ch, TF_COUNT, {8'h00, xf_count}, OC_OK, 8'h00);
						emit(KIND_REG_WR, ch, TF_LBA_LO, {8'h00, xf_lba[7:0]}, OC_OK, 8'h00);
						emit(KIND_REG_WR, ch, TF_LBA_MID, {8'h00, xf_lba[15:8]}, OC_OK, 8'h00);
						emit(KIND_REG_WR, ch, TF_LBA_HI, {8'h00, xf_lba[23:16]}, OC_OK, 8'h00);
						emit(KIND_REG_WR, ch, TF_COMMAND,
							{8'h00, xf_write ? CMD_WRITE : CMD_READ}, OC_OK, 8'h00);
						enter_wait(xf_write ? XF_DRQ : XF_NBUSY);
					end else if (poll_exhausted())
						finish_xfer(OC_TIMEOUT, 8'h00);
				end
				XF_NBUSY: begin
					if (!it.status_byte[ST_BSY_BIT])
						enter_wait(XF_DRQ);
					else if (poll_exhausted())
						finish_xfer(OC_TIMEOUT, 8'h00);
				end
				XF_DRQ: begin
					if (it.status_byte[ST_DRQ_BIT]) begin
						xf_phase = XF_DATA;
						xf_word  = 0;
					end else if (it.status_byte[ST_ERR_BIT])
						finish_xfer(OC_DEV_ERR, it.error_byte);
					else if (poll_exhausted())
						finish_xfer(OC_TIMEOUT, 8'h00);
				end
				XF_FLUSH: begin
					if (!it.status_byte[ST_BSY_BIT]) begin
						xf_sectors = xf_sectors - 8'd1;
						if (xf_sectors == 8'd0)
							finish_xfer(OC_OK, 8'h00);
						else
							enter_wait(XF_DRQ);
					end else if (poll_exhausted())
						finish_xfer(OC_TIMEOUT, 8'h00);
				end
				default: ;
			endcase
		end else if (it.action == ACT_DATA && xf_phase == XF_DATA) begin
			step_used = 1'b1;
			emit(xf_write ? KIND_REG_WR : KIND_HOST_WD, ch, TF_DATA, it.data_word,
				OC_OK, 8'h00);
			xf_word++;
			if (xf_word >= WORDS_PER_SECTOR) begin
				xf_word = 0;
				if (xf_write) begin
					// every written sector is followed by a cache flush
					emit(KIND_REG_WR, ch, TF_COMMAND, {8'h00, CMD_FLUSH}, OC_OK, 8'h00);
					enter_wait(XF_FLUSH);
				end else begin
					xf_sectors = xf_sectors - 8'd1;
					if (xf_sectors == 8'd0)
						finish_xfer(OC_OK, 8'h00);
					else
						enter_wait(XF_NBUSY);
				end
			end
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic void cmp_field(string name, logic [15:0] want_v, logic [15:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
			mismatches++;
		end
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		if (xfer_results_due.size() == 0) begin
			$display("%0t: result %h with nothing expected", $time, got);
			mismatches++;
		end else begin
			want = xfer_results_due.pop_front();
			cmp_field("kind", 16'(want.kind), 16'(got.kind));
			cmp_field("channel", 16'(want.channel), 16'(got.channel));
			cmp_field("reg_offset", 16'(want.reg_offset), 16'(got.reg_offset));
			cmp_field("value", want.value, got.value);
			cmp_field("outcome", 16'(want.outcome), 16'(got.outcome));
			cmp_field("device_error", 16'(want.device_error), 16'(got.device_error));
			cmp_field("last", 16'(want.last), 16'(got.last));
		end
	endfunction

	// receiver: checks each popped result, then decides pop for the next edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_result(result);
		pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog: any transfer on any channel counts as progress
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ata_pio_sector_transfer test failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	// one input transfer; prediction happens at the accepting edge
	task automatic send_item(input item_t it, input logic typed, input result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_transfer(it);
		if (typed)
			xfer_results_due.push_back(want);
		else
			foreach (step_results[i])
				xfer_results_due.push_back(step_results[i]);
	endtask

	// sender holds off until every outstanding result has been popped
	task automatic hold_until_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (xfer_results_due.size() != 0);
	endtask

	// register writes only with the block idle and drained
	task automatic write_cfg(input logic idx, input logic [15:0] val);
		hold_until_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_PRESENT_MASK)
			cfg_present = val[3:0];
		else
			cfg_poll_limit = val;
	endtask

	function automatic stim_row_t xfer_row(logic [1:0] act, logic [2:0] drv,
			logic [27:0] lba, logic [7:0] cnt, logic [7:0] st, logic [7:0] er,
			logic [15:0] dw, logic typed, logic [1:0] oc, logic [7:0] err);
		stim_row_t r;
		r                   = '0;
		r.it.action         = act;
		r.it.drive_index    = drv;
		r.it.lba            = lba;
		r.it.num_sectors    = cnt;
		r.it.status_byte    = st;
		r.it.error_byte     = er;
		r.it.data_word      = dw;
		r.typed             = typed;
		r.want.kind         = KIND_DONE;
		r.want.outcome      = oc;
		r.want.device_error = err;
		r.want.last         = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic idx, logic [15:0] val);
		stim_row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	// Random item chosen from the predicted phase: mostly what a healthy
	// device would send next, with some misplaced items mixed in.
	function automatic item_t pick_item();
		item_t it;
		int r;
		int rc;
		it.action       = ACT_STATUS;
		it.drive_index  = 3'($urandom_range(7));
		it.lba          = 28'($urandom);
		it.num_sectors  = 8'($urandom);
		it.status_byte  = 8'($urandom);
		it.error_byte   = 8'($urandom);
		it.data_word    = 16'($urandom);
		r = $urandom_range(99);
		case (xf_phase)
			XF_IDLE: begin
				if (r < 8)
					it.action = (r < 4) ? ACT_STATUS : ACT_DATA;
				else begin
					it.action = $urandom_range(1) ? ACT_START_WR : ACT_START_RD;
					if (cfg_present != 4'h0 && $urandom_range(99) < 85)
						do
							it.drive_index = 3'($urandom_range(3));
						while (!cfg_present[it.drive_index[1:0]]);
					rc = $urandom_range(99);
					if (rc < 10)
						it.num_sectors = 8'd0;
					else if (rc < 60)
						it.num_sectors = 8'd1;
					else if (rc < 85)
						it.num_sectors = 8'd2;
					else
						it.num_sectors = 8'($urandom_range(3, 255));
				end
			end
			XF_DATA: begin
				if (r < 3)
					it.action = (r == 0) ? ACT_START_RD : ACT_STATUS;
				else
					it.action = ACT_DATA;
			end
			XF_DRQ: begin
				// random transfers stop at the first DRQ wait, by ERR or by
				// running out of polls; only the sector the table opens runs to its end
				if (r < 4)
					it.action = (r < 2) ? ACT_DATA : ACT_START_WR;
				else if (r < 20) begin
					it.status_byte[ST_DRQ_BIT] = 1'b0;
					it.status_byte[ST_ERR_BIT] = 1'b0;
				end else begin
					it.status_byte[ST_DRQ_BIT] = 1'b0;
					it.status_byte[ST_ERR_BIT] = 1'b1;
				end
			end
			default: begin
				// ready, not-busy and flush waits only look at BSY
				if (r < 4)
					it.action = (r < 2) ? ACT_DATA : ACT_START_RD;
				else
					it.status_byte[ST_BSY_BIT] = (r < 34);
			end
		endcase
		return it;
	endfunction

	// random traffic until the budget is spent and the last transfer is over
	task automatic run_traffic(input int budget);
		int counted;
		item_t it;
		counted = 0;
		while (counted < budget || xf_phase != XF_IDLE) begin
			it = pick_item();
			send_item(it, 1'b0, '0);
			if (step_used)
				counted++;
			if ((step_used && counted == 8) || $urandom_range(99) == 0)
				hold_until_drained();
		end
	endtask

	initial begin
		int p;
		cfg_present    = 4'h0;
		cfg_poll_limit = POLL_LIMIT_RST;
		xf_phase       = XF_IDLE;
		xf_polls       = '0;
		xf_word        = 0;
		xf_sectors     = '0;
		xf_drive       = '0;
		xf_write       = 1'b0;
		xf_lba         = '0;
		xf_count       = '0;

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed corner cases ---
		// nothing present after reset: any start is a bad drive
		rows.push_back(xfer_row(ACT_START_RD, 3'd0, 28'h0, 8'd1, 8'h00, 8'h00, 16'h0,
			1'b1, OC_BAD_DRIVE, 8'h00));
		// status and data in idle are dropped
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h00, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_DATA, 3'd0, 28'h0, 8'd0, 8'h00, 8'h00, 16'hFFFF,
			1'b0, OC_OK, 8'h00));
		rows.push_back(cfg_row(REG_PRESENT_MASK, 16'h000F));
		// index beyond the drive slots
		rows.push_back(xfer_row(ACT_START_WR, 3'd7, 28'h0, 8'd5, 8'h00, 8'h00, 16'h0,
			1'b1, OC_BAD_DRIVE, 8'h00));
		// zero count finishes at once
		rows.push_back(xfer_row(ACT_START_RD, 3'd3, 28'h0, 8'd0, 8'h00, 8'h00, 16'h0,
			1'b1, OC_OK, 8'h00));
		// write at top LBA and full count, one busy poll, stray items, then ERR
		rows.push_back(xfer_row(ACT_START_WR, 3'd1, 28'hFFFFFFF, 8'hFF, 8'h00, 8'h00,
			16'h0, 1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h80, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_START_RD, 3'd0, 28'h0, 8'd1, 8'h00, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_DATA, 3'd0, 28'h0, 8'd0, 8'h00, 8'h00, 16'h1234,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h00, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h01, 8'hFF, 16'h0,
			1'b1, OC_DEV_ERR, 8'hFF));
		// single failed poll allowed: the first busy sample times out
		rows.push_back(cfg_row(REG_POLL_LIMIT, 16'h0001));
		rows.push_back(xfer_row(ACT_START_RD, 3'd2, 28'h1, 8'd1, 8'h00, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h80, 8'h00, 16'h0,
			1'b1, OC_TIMEOUT, 8'h00));
		// secondary channel read, through not-busy into an ERR with error 0
		rows.push_back(cfg_row(REG_POLL_LIMIT, 16'hFFFF));
		rows.push_back(xfer_row(ACT_START_RD, 3'd2, 28'h1234567, 8'd2, 8'h00, 8'h00,
			16'h0, 1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h7F, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h00, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'hF7, 8'h00, 16'h0,
			1'b1, OC_DEV_ERR, 8'h00));
		// write into the data phase; a status sample there is dropped
		rows.push_back(xfer_row(ACT_START_WR, 3'd0, 28'h0, 8'd1, 8'h00, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h00, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'h08, 8'h00, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_DATA, 3'd0, 28'h0, 8'd0, 8'h00, 8'h00, 16'hFFFF,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_STATUS, 3'd0, 28'h0, 8'd0, 8'hFF, 8'hFF, 16'h0,
			1'b0, OC_OK, 8'h00));
		rows.push_back(xfer_row(ACT_DATA, 3'd0, 28'h0, 8'd0, 8'h00, 8'h00, 16'h0000,
			1'b0, OC_OK, 8'h00));

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_cfg(rows[i].cfg_idx, rows[i].cfg_val);
			else
				send_item(rows[i].it, rows[i].typed, rows[i].want);
		end

		// finish the sector left open by the table (write, flush, not-busy)
		run_traffic(0);

		// --- random traffic under three stall profiles ---
		for (p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 50;
					write_cfg(REG_PRESENT_MASK, 16'($urandom_range(1, 14)));
					write_cfg(REG_POLL_LIMIT, 16'd3);
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 38;
					write_cfg(REG_PRESENT_MASK, 16'h000F);
					write_cfg(REG_POLL_LIMIT, 16'd1);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					write_cfg(REG_PRESENT_MASK, 16'($urandom_range(1, 14)));
					write_cfg(REG_POLL_LIMIT, 16'($urandom_range(2, 6)));
				end
			endcase
			run_traffic(PHASE_ITEMS);
		end

		// drain, then leave room for any stray result
		hold_until_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("ata_pio_sector_transfer test passed");
		else
			$display("ata_pio_sector_transfer test failed");
		$finish;
	end

endmodule
